// ===== hdl/fmsp_pkg.sv =====
// fmsp_pkg: shared types and constants for the permission spec parser
`default_nettype none

package fmsp_pkg;

    // mode word and default spec length limit
    localparam int MODE_W              = 12;
    localparam int OCT_W               = 64;
    localparam int MAX_SPEC_CHARS_DEF  = 255;

    localparam logic [MODE_W-1:0] MODE_ALL   = 12'o7777;
    localparam logic [MODE_W-1:0] WHO_USER   = 12'o4700;
    localparam logic [MODE_W-1:0] WHO_GROUP  = 12'o2070;
    localparam logic [MODE_W-1:0] WHO_OTHER  = 12'o1007;
    localparam logic [MODE_W-1:0] PERM_READ  = 12'o0444;
    localparam logic [MODE_W-1:0] PERM_WRITE = 12'o0222;
    localparam logic [MODE_W-1:0] PERM_EXEC  = 12'o0111;
    localparam logic [MODE_W-1:0] PERM_SETID = 12'o6000;
    localparam logic [MODE_W-1:0] PERM_STICK = 12'o1000;

    // clause phase codes
    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_WHO   = 2'd1;
    localparam logic [1:0] PHASE_PERM  = 2'd2;

    // operator codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_SET = 2'd2;

    // character codes
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_BIG_X = 8'h58;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;

    // parse state carried from character to character
    typedef struct packed {
        logic [MODE_W-1:0] running_mode;
        logic              dir_flag;
        logic              octal_kind;
        logic [1:0]        clause_phase;
        logic [MODE_W-1:0] who_mask;
        logic              who_given;
        logic [1:0]        op_kind;
        logic [MODE_W-1:0] perm_mask;
        logic              error_flag;
        logic [OCT_W-1:0]  octal_accum;
        logic              octal_overflow;
    } parse_state_t;

endpackage

`default_nettype wire

// ===== hdl/fmsp_step.sv =====
// fmsp_step: next parse state and result for one spec character
`default_nettype none

module fmsp_step
    import fmsp_pkg::*;
#(
    parameter int MAX_SPEC_CHARS = MAX_SPEC_CHARS_DEF,
    parameter int CNT_W          = $clog2(MAX_SPEC_CHARS + 1)
) (
    input  wire parse_state_t      state_in,
    input  wire logic [CNT_W-1:0]  cnt_in,
    input  wire logic [7:0]        ch,
    input  wire logic              first,
    input  wire logic              last,
    input  wire logic [MODE_W-1:0] cur_mode,
    input  wire logic              is_directory,
    output parse_state_t           state_out,
    output logic [CNT_W-1:0]       cnt_out,
    output logic [MODE_W-1:0]      res_mode,
    output logic                   res_ok
);

    // drop the clause fields
    function automatic parse_state_t clear_clause(parse_state_t s);
        parse_state_t r;
        r              = s;
        r.clause_phase = PHASE_EMPTY;
        r.who_mask     = '0;
        r.who_given    = 1'b0;
        r.op_kind      = OP_ADD;
        r.perm_mask    = '0;
        return r;
    endfunction

    // drop clause and spec fields, keep mode, directory flag and kind
    function automatic parse_state_t clear_parse(parse_state_t s);
        parse_state_t r;
        r                = clear_clause(s);
        r.error_flag     = 1'b0;
        r.octal_accum    = '0;
        r.octal_overflow = 1'b0;
        return r;
    endfunction

    // apply the open clause to the running mode, or flag an error for a clause with no operator
    function automatic parse_state_t end_clause(parse_state_t s);
        parse_state_t      r;
        logic [MODE_W-1:0] who;
        logic [MODE_W-1:0] bits;
        r    = s;
        who  = s.who_given ? s.who_mask : MODE_ALL;
        bits = s.perm_mask & who;
        if (s.clause_phase == PHASE_WHO) begin
            r.error_flag = 1'b1;
        end else if (s.clause_phase == PHASE_PERM) begin
            case (s.op_kind)
                OP_ADD:  r.running_mode = s.running_mode | bits;
                OP_SUB:  r.running_mode = s.running_mode & ~bits;
                default: r.running_mode = (s.running_mode & ~who) | bits;
            endcase
        end
        return clear_clause(r);
    endfunction

    parse_state_t      st;
    logic [CNT_W-1:0]  cnt;
    logic [MODE_W-1:0] result;
    logic              ok;

    always_comb begin
        st     = state_in;
        cnt    = cnt_in;
        result = '0;
        ok     = 1'b0;

        // first character loads the file context and restarts the spec
        if (first) begin
            st              = clear_parse(st);
            st.running_mode = cur_mode;
            st.dir_flag     = is_directory;
            st.octal_kind   = (ch inside {[CH_0:CH_9]});
            cnt             = '0;
        end

        // consume the character
        if (!st.error_flag) begin
            if (st.octal_kind) begin
                if (ch inside {[CH_0:CH_7]}) begin
                    if (st.octal_overflow || (|st.octal_accum[OCT_W-1:OCT_W-3])) begin
                        st.octal_overflow = 1'b1;
                    end else begin
                        st.octal_accum = {st.octal_accum[OCT_W-4:0], ch[2:0]};
                    end
                end else begin
                    st.error_flag = 1'b1;
                end
            end else if (cnt < CNT_W'(MAX_SPEC_CHARS)) begin
                cnt = cnt + 1'b1;
                if (ch == CH_COMMA) begin
                    st = end_clause(st);
                end else if (st.clause_phase != PHASE_PERM) begin
                    // who letters and operator
                    case (ch)
                        CH_U: begin
                            st.who_mask     = st.who_mask | WHO_USER;
                            st.who_given    = 1'b1;
                            st.clause_phase = PHASE_WHO;
                        end
                        CH_G: begin
                            st.who_mask     = st.who_mask | WHO_GROUP;
                            st.who_given    = 1'b1;
                            st.clause_phase = PHASE_WHO;
                        end
                        CH_O: begin
                            st.who_mask     = st.who_mask | WHO_OTHER;
                            st.who_given    = 1'b1;
                            st.clause_phase = PHASE_WHO;
                        end
                        CH_A: begin
                            st.who_mask     = MODE_ALL;
                            st.who_given    = 1'b1;
                            st.clause_phase = PHASE_WHO;
                        end
                        CH_PLUS: begin
                            st.op_kind      = OP_ADD;
                            st.clause_phase = PHASE_PERM;
                        end
                        CH_MINUS: begin
                            st.op_kind      = OP_SUB;
                            st.clause_phase = PHASE_PERM;
                        end
                        CH_EQUAL: begin
                            st.op_kind      = OP_SET;
                            st.clause_phase = PHASE_PERM;
                        end
                        default: st.error_flag = 1'b1;
                    endcase
                end else begin
                    // permission letters
                    case (ch)
                        CH_R: st.perm_mask = st.perm_mask | PERM_READ;
                        CH_W: st.perm_mask = st.perm_mask | PERM_WRITE;
                        CH_X: st.perm_mask = st.perm_mask | PERM_EXEC;
                        CH_BIG_X: begin
                            if (st.dir_flag || (|(st.running_mode & PERM_EXEC))) begin
                                st.perm_mask = st.perm_mask | PERM_EXEC;
                            end
                        end
                        CH_S: st.perm_mask = st.perm_mask | PERM_SETID;
                        CH_T: st.perm_mask = st.perm_mask | PERM_STICK;
                        default: st.error_flag = 1'b1;
                    endcase
                end
            end
        end

        // end of spec: close the clause, form the result, clear the parse
        if (last) begin
            if (!st.octal_kind && !st.error_flag) begin
                st = end_clause(st);
            end
            ok = !st.error_flag;
            if (ok) begin
                if (st.octal_kind) begin
                    result = st.octal_overflow ? MODE_ALL : st.octal_accum[MODE_W-1:0];
                end else begin
                    result = st.running_mode;
                end
                st.running_mode = result;
            end
            st  = clear_parse(st);
            cnt = '0;
        end
    end

    assign state_out = st;
    assign cnt_out   = cnt;
    assign res_mode  = result;
    assign res_ok    = ok;

endmodule

`default_nettype wire

// ===== hdl/file_mode_spec_parser.sv =====
// file_mode_spec_parser: top level with input register, parse state and result register
// a character is held in the input register and parsed from there; the parse step
// loads its result, if any, into the result register, where it waits until transferred
// throughput: one character per cycle while nothing stalls, set by the combinational parse step
// the input side keeps accepting while a result waits, unless a last character must stall
// reset: synchronous active-low aresetn clears valids, parse state and character count to zero
`default_nettype none

module file_mode_spec_parser
    import fmsp_pkg::*;
#(
    parameter int MAX_SPEC_CHARS = MAX_SPEC_CHARS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_ch,
    input  wire logic              s_first,
    input  wire logic              s_last,
    input  wire logic [MODE_W-1:0] s_cur_mode,
    input  wire logic              s_is_directory,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [MODE_W-1:0]      m_new_mode,
    output logic                   m_ok
);

    localparam int CNT_W = $clog2(MAX_SPEC_CHARS + 1);

    logic              in_valid_reg;
    logic [7:0]        in_ch_reg;
    logic              in_first_reg;
    logic              in_last_reg;
    logic [MODE_W-1:0] in_cur_mode_reg;
    logic              in_is_dir_reg;

    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic              m_valid_reg;
    logic [MODE_W-1:0] m_new_mode_reg;
    logic              m_ok_reg;
    logic [MODE_W-1:0] res_mode;
    logic              res_ok;

    logic              out_free;
    logic              proc_fire;
    logic              res_fire;

    // handshake: a character is parsed when its result, if any, has room
    assign out_free  = !m_valid_reg || m_ready;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign res_fire  = proc_fire && in_last_reg;
    assign s_ready   = !in_valid_reg || proc_fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_ch_reg       <= s_ch;
            in_first_reg    <= s_first;
            in_last_reg     <= s_last;
            in_cur_mode_reg <= s_cur_mode;
            in_is_dir_reg   <= s_is_directory;
        end
    end

    // parse step
    fmsp_step #(
        .MAX_SPEC_CHARS (MAX_SPEC_CHARS),
        .CNT_W          (CNT_W)
    ) u_step (
        .state_in     (state_reg),
        .cnt_in       (cnt_reg),
        .ch           (in_ch_reg),
        .first        (in_first_reg),
        .last         (in_last_reg),
        .cur_mode     (in_cur_mode_reg),
        .is_directory (in_is_dir_reg),
        .state_out    (state_next),
        .cnt_out      (cnt_next),
        .res_mode     (res_mode),
        .res_ok       (res_ok)
    );

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            cnt_reg   <= '0;
        end else if (proc_fire) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_fire) begin
            m_new_mode_reg <= res_mode;
            m_ok_reg       <= res_ok;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_new_mode = m_new_mode_reg;
    assign m_ok       = m_ok_reg;

    // a finished spec leaves a clean parse state
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> (state_reg.clause_phase == PHASE_EMPTY) && !state_reg.error_flag
                     && !state_reg.octal_overflow && (cnt_reg == '0))
        else $error("parse state not cleared after result");

    // a rejected spec reports mode zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_new_mode == '0))
        else $error("invalid spec with nonzero mode");

    // a stalled character is held in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !proc_fire) |=> in_valid_reg && $stable(in_ch_reg)
                                         && $stable(in_last_reg))
        else $error("stalled character lost");

    // a result is never overwritten before transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !res_fire)
        else $error("result overwritten");

endmodule

`default_nettype wire
